[src/abkf_pkg.sv]
`default_nettype none
package abkf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int IO_W           = 32;
    localparam int COV_W          = 32;
    localparam int COV_FRAC       = 24;
    localparam int DT_W           = 16;
    localparam int DT_FRAC        = 16;
    localparam int REG_W          = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int OP_W           = 4;
    localparam int DIV_STEPS      = 32;
    localparam int DIV_CNT_W      = 5;

    localparam logic [REG_W-1:0] QA_RST = 24'd16777;
    localparam logic [REG_W-1:0] QB_RST = 24'd50332;
    localparam logic [REG_W-1:0] R_RST  = 24'd503316;

    localparam logic [CFG_IDX_W-1:0] REG_QA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R  = 2'd2;

    // multiply / writeback operations
    localparam logic [OP_W-1:0] OP_RATE = 4'd0;
    localparam logic [OP_W-1:0] OP_T    = 4'd1;
    localparam logic [OP_W-1:0] OP_P00  = 4'd2;
    localparam logic [OP_W-1:0] OP_P11  = 4'd3;
    localparam logic [OP_W-1:0] OP_ANG  = 4'd4;
    localparam logic [OP_W-1:0] OP_BIAS = 4'd5;
    localparam logic [OP_W-1:0] OP_C00  = 4'd6;
    localparam logic [OP_W-1:0] OP_C01  = 4'd7;
    localparam logic [OP_W-1:0] OP_C10  = 4'd8;
    localparam logic [OP_W-1:0] OP_C11  = 4'd9;

    typedef struct packed {
        logic            load;
        logic            mul_lo;
        logic            mul_hi;
        logic            wb;
        logic            div_start;
        logic            div_step;
        logic            gain;
        logic            out_load;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic s_pos;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[src/angle_bias_kalman_filter.sv]
`default_nettype none
// Two-state angle and gyro bias Kalman filter. One transaction on the input
// channel yields one transaction on the output channel. An item goes from
// acceptance to its result register through ten products on one shared
// two-pass multiplier (low pass, high pass, writeback for each), a 32-step
// restoring divider that forms both gains at once and a gain stage; when the
// innovation variance is not positive the correction is skipped. The
// input is taken only while no item is in work. Configuration writes are
// accepted every cycle and must only be made while the block is idle.
module angle_bias_kalman_filter #(
    parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_measured_angle,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_gyro_rate,
    input  wire logic [abkf_pkg::DT_W-1:0]        i_time_step,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [abkf_pkg::IO_W-1:0]      o_filtered_angle,
    output logic signed [abkf_pkg::IO_W-1:0]      o_unbiased_rate,
    output logic signed [abkf_pkg::IO_W-1:0]      o_bias_estimate,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [abkf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [abkf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import abkf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    abkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    abkf_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured_angle (i_measured_angle),
        .i_gyro_rate      (i_gyro_rate),
        .i_time_step      (i_time_step),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_angle (o_filtered_angle),
        .o_unbiased_rate  (o_unbiased_rate),
        .o_bias_estimate  (o_bias_estimate)
    );

endmodule
`default_nettype wire

[src/abkf_ctrl.sv]
`default_nettype none
module abkf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire abkf_pkg::t_sts i_sts,
    output abkf_pkg::t_cmd     o_cmd
);
    import abkf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MLO  = 3'd1;
    localparam logic [2:0] S_MHI  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_GAIN = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_RATE;
                    n_state    = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_op == OP_P11) begin
                    if (i_sts.s_pos) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_op == OP_C11) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = r_op + OP_W'(1);
                    n_state = S_MLO;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_op       = OP_ANG;
                n_state    = S_MLO;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_RATE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[src/abkf_dp.sv]
`default_nettype none
module abkf_dp #(
    parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire abkf_pkg::t_cmd                         i_cmd,
    output abkf_pkg::t_sts                              o_sts,
    input  wire logic                                   i_cfg_valid,
    input  wire logic [abkf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [abkf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [abkf_pkg::IO_W-1:0]       i_measured_angle,
    input  wire logic signed [abkf_pkg::IO_W-1:0]       i_gyro_rate,
    input  wire logic [abkf_pkg::DT_W-1:0]              i_time_step,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [abkf_pkg::IO_W-1:0]            o_filtered_angle,
    output logic signed [abkf_pkg::IO_W-1:0]            o_unbiased_rate,
    output logic signed [abkf_pkg::IO_W-1:0]            o_bias_estimate
);
    import abkf_pkg::*;

    localparam int A_W  = (DATA_WIDTH + 2 > 36) ? DATA_WIDTH + 2 : 36;
    localparam int B_W  = 34;
    localparam int LO_W = 24;
    localparam int P_W  = A_W + B_W;
    localparam int V_W  = P_W + 2;
    localparam int S_W  = 34;
    localparam int Q_W  = 32;

    function automatic logic signed [63:0] sat_w(input logic signed [V_W-1:0] v,
                                                 input int w);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        hi = (V_W'(1) <<< (w - 1)) - V_W'(1);
        lo = -hi - V_W'(1);
        if (v > hi) begin
            sat_w = 64'(hi);
        end else if (v < lo) begin
            sat_w = 64'(lo);
        end else begin
            sat_w = 64'(v);
        end
    endfunction

    function automatic logic [COV_W-1:0] gain_sat(input logic [Q_W-1:0] q,
                                                  input logic ov, input logic neg);
        if (neg) begin
            if (ov || q > 32'h8000_0000) begin
                gain_sat = 32'h8000_0000;
            end else begin
                gain_sat = ~q + 32'd1;
            end
        end else if (ov || q[Q_W-1]) begin
            gain_sat = 32'h7FFF_FFFF;
        end else begin
            gain_sat = q;
        end
    endfunction

    // configuration
    logic [REG_W-1:0] r_qa, r_qb, r_r;

    // filter state and step operands
    logic signed [DATA_WIDTH-1:0] r_ang, r_bias, r_meas, r_rate, r_y;
    logic signed [COV_W-1:0]      r_p00, r_p01, r_p10, r_p11;
    logic signed [COV_W-1:0]      r_k0, r_k1, r_o00, r_o01;
    logic signed [S_W-1:0]        r_t;
    logic [DT_W-1:0]              r_dt;
    logic signed [P_W-1:0]        r_acc, r_prod;

    // divider
    logic [S_W-1:0] r_s, r_rem0, r_rem1;
    logic [Q_W-1:0] r_q0, r_q1;
    logic           r_ov0, r_ov1, r_neg0, r_neg1;

    // output register
    logic                    r_out_valid;
    logic signed [IO_W-1:0]  r_o_ang, r_o_rate, r_o_bias;

    logic signed [A_W-1:0]            mul_a;
    logic signed [B_W-1:0]            mul_b, dt_s;
    logic signed [LO_W:0]             a_lo;
    logic signed [A_W-LO_W-1:0]       a_hi;
    logic signed [LO_W+B_W:0]         pp_lo;
    logic signed [A_W-LO_W+B_W-1:0]   pp_hi;
    logic signed [P_W-1:0]            sh16, sh24;
    logic signed [63:0] meas_in, gyro_in, rate_in, y_new;
    logic signed [63:0] ang_pred, p00_pred, p01_pred, p10_pred, p11_pred;
    logic signed [63:0] k_y, ang_cor, bias_cor, c00, c01, c10, c11;
    logic signed [S_W:0] s_sum;
    logic [COV_W-1:0]    mag00, mag10;
    logic [S_W:0]        d0, d1;
    logic                ge0, ge1;

    assign dt_s = B_W'($signed({1'b0, r_dt}));

    always_comb begin
        case (i_cmd.op)
            OP_RATE: begin
                mul_a = A_W'(r_rate);
                mul_b = dt_s;
            end
            OP_T: begin
                mul_a = A_W'(r_p11);
                mul_b = dt_s;
            end
            OP_P00: begin
                mul_a = A_W'(r_t) - A_W'(r_p01) - A_W'(r_p10) + A_W'($signed({1'b0, r_qa}));
                mul_b = dt_s;
            end
            OP_P11: begin
                mul_a = A_W'($signed({1'b0, r_qb}));
                mul_b = dt_s;
            end
            OP_ANG: begin
                mul_a = A_W'(r_y);
                mul_b = B_W'(r_k0);
            end
            OP_BIAS: begin
                mul_a = A_W'(r_y);
                mul_b = B_W'(r_k1);
            end
            OP_C00: begin
                mul_a = A_W'(r_o00);
                mul_b = B_W'(r_k0);
            end
            OP_C01: begin
                mul_a = A_W'(r_o01);
                mul_b = B_W'(r_k0);
            end
            OP_C10: begin
                mul_a = A_W'(r_o00);
                mul_b = B_W'(r_k1);
            end
            default: begin
                mul_a = A_W'(r_o01);
                mul_b = B_W'(r_k1);
            end
        endcase
    end

    // product in two partial products, low 24 bits of a first
    assign a_lo  = $signed({1'b0, mul_a[LO_W-1:0]});
    assign a_hi  = mul_a[A_W-1:LO_W];
    assign pp_lo = a_lo * mul_b;
    assign pp_hi = a_hi * mul_b;

    assign sh16 = r_prod >>> DT_FRAC;
    assign sh24 = r_prod >>> COV_FRAC;

    assign meas_in  = sat_w(V_W'(i_measured_angle), DATA_WIDTH);
    assign gyro_in  = sat_w(V_W'(i_gyro_rate), DATA_WIDTH);
    assign rate_in  = sat_w(V_W'(gyro_in) - V_W'(r_bias), DATA_WIDTH);
    assign y_new    = sat_w(V_W'(r_meas) - V_W'(r_ang), DATA_WIDTH);

    assign ang_pred = sat_w(V_W'(r_ang) + V_W'(sh16), DATA_WIDTH);
    assign p00_pred = sat_w(V_W'(r_p00) + V_W'(sh16), COV_W);
    assign p01_pred = sat_w(V_W'(r_p01) - V_W'(r_t), COV_W);
    assign p10_pred = sat_w(V_W'(r_p10) - V_W'(r_t), COV_W);
    assign p11_pred = sat_w(V_W'(r_p11) + V_W'(sh16), COV_W);

    assign k_y      = sat_w(V_W'(sh24), DATA_WIDTH);
    assign ang_cor  = sat_w(V_W'(r_ang) + V_W'(k_y), DATA_WIDTH);
    assign bias_cor = sat_w(V_W'(r_bias) + V_W'(k_y), DATA_WIDTH);
    assign c00      = sat_w(V_W'(r_p00) - V_W'(sh24), COV_W);
    assign c01      = sat_w(V_W'(r_p01) - V_W'(sh24), COV_W);
    assign c10      = sat_w(V_W'(r_p10) - V_W'(sh24), COV_W);
    assign c11      = sat_w(V_W'(r_p11) - V_W'(sh24), COV_W);

    // innovation variance
    assign s_sum = (S_W+1)'(r_p00) + (S_W+1)'($signed({1'b0, r_r}));
    assign mag00 = r_p00[COV_W-1] ? (~r_p00 + 32'd1) : r_p00;
    assign mag10 = r_p10[COV_W-1] ? (~r_p10 + 32'd1) : r_p10;

    assign d0  = {r_rem0, r_q0[Q_W-1]};
    assign d1  = {r_rem1, r_q1[Q_W-1]};
    assign ge0 = d0 >= {1'b0, r_s};
    assign ge1 = d1 >= {1'b0, r_s};

    assign o_sts.s_pos    = s_sum > 0;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa        <= QA_RST;
            r_qb        <= QB_RST;
            r_r         <= R_RST;
            r_ang       <= '0;
            r_bias      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_QA:  r_qa <= i_cfg_data[REG_W-1:0];
                    REG_QB:  r_qb <= i_cfg_data[REG_W-1:0];
                    REG_R:   r_r  <= i_cfg_data[REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wb) begin
                case (i_cmd.op)
                    OP_RATE: r_ang  <= ang_pred[DATA_WIDTH-1:0];
                    OP_P00: begin
                        r_p00 <= p00_pred[COV_W-1:0];
                        r_p01 <= p01_pred[COV_W-1:0];
                        r_p10 <= p10_pred[COV_W-1:0];
                    end
                    OP_P11:  r_p11  <= p11_pred[COV_W-1:0];
                    OP_ANG:  r_ang  <= ang_cor[DATA_WIDTH-1:0];
                    OP_BIAS: r_bias <= bias_cor[DATA_WIDTH-1:0];
                    OP_C00:  r_p00  <= c00[COV_W-1:0];
                    OP_C01:  r_p01  <= c01[COV_W-1:0];
                    OP_C10:  r_p10  <= c10[COV_W-1:0];
                    OP_C11:  r_p11  <= c11[COV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= meas_in[DATA_WIDTH-1:0];
            r_rate <= rate_in[DATA_WIDTH-1:0];
            r_dt   <= i_time_step;
        end
        if (i_cmd.mul_lo) begin
            r_acc <= P_W'(pp_lo);
        end
        if (i_cmd.mul_hi) begin
            r_prod <= r_acc + (P_W'(pp_hi) <<< LO_W);
        end
        if (i_cmd.wb && i_cmd.op == OP_T) begin
            r_t <= S_W'(sh16);
        end
        if (i_cmd.div_start) begin
            r_o00  <= r_p00;
            r_o01  <= r_p01;
            r_y    <= y_new[DATA_WIDTH-1:0];
            r_s    <= s_sum[S_W-1:0];
            r_neg0 <= r_p00[COV_W-1];
            r_neg1 <= r_p10[COV_W-1];
            r_ov0  <= S_W'(mag00[COV_W-1:8]) >= s_sum[S_W-1:0];
            r_ov1  <= S_W'(mag10[COV_W-1:8]) >= s_sum[S_W-1:0];
            r_rem0 <= S_W'(mag00[COV_W-1:8]);
            r_rem1 <= S_W'(mag10[COV_W-1:8]);
            r_q0   <= {mag00[7:0], 24'd0};
            r_q1   <= {mag10[7:0], 24'd0};
        end
        if (i_cmd.div_step) begin
            r_rem0 <= ge0 ? S_W'(d0 - {1'b0, r_s}) : d0[S_W-1:0];
            r_rem1 <= ge1 ? S_W'(d1 - {1'b0, r_s}) : d1[S_W-1:0];
            r_q0   <= {r_q0[Q_W-2:0], ge0};
            r_q1   <= {r_q1[Q_W-2:0], ge1};
        end
        if (i_cmd.gain) begin
            r_k0 <= gain_sat(r_q0, r_ov0, r_neg0);
            r_k1 <= gain_sat(r_q1, r_ov1, r_neg1);
        end
        if (i_cmd.out_load) begin
            r_o_ang  <= IO_W'(r_ang);
            r_o_rate <= IO_W'(r_rate);
            r_o_bias <= IO_W'(r_bias);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_angle = r_o_ang;
    assign o_unbiased_rate  = r_o_rate;
    assign o_bias_estimate  = r_o_bias;

endmodule
`default_nettype wire

[test/kf_state_checker.sv]
`timescale 1ns / 1ps
module kf_state_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_measured_angle,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_gyro_rate,
    input  wire logic [abkf_pkg::DT_W-1:0]        i_time_step,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_filtered_angle,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_unbiased_rate,
    input  wire logic signed [abkf_pkg::IO_W-1:0] i_bias_estimate,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [abkf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [abkf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import abkf_pkg::*;

    typedef struct {
        logic [31:0] angle;
        logic [31:0] rate;
        logic [31:0] bias;
    } kf_result_t;

    kf_result_t expected_estimates[$];

    logic [REG_W-1:0] angle_noise, bias_noise, meas_noise;
    longint angle_est, bias_est;
    longint cov[4];

    function automatic longint sat(longint v, int w);
        longint hi, lo;
        if (w >= 64) return v;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(a*b / 2^sh), saturated to w bits
    function automatic longint fixmul(longint a, longint b, int sh, int w);
        logic signed [127:0] ea, eb, pr, hi, lo;
        ea = 128'(a);
        eb = 128'(b);
        pr = (ea * eb) >>> sh;
        hi = (128'sd1 <<< (w - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (pr > hi) pr = hi;
        if (pr < lo) pr = lo;
        return longint'(pr);
    endfunction

    function automatic longint gain(longint p, longint s);
        logic [63:0] m, q;
        longint v;
        m = (p < 0) ? -p : p;
        q = (m << COV_FRAC) / $unsigned(s);
        v = (q > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : q;
        if (p < 0) v = -v;
        return sat(v, COV_W);
    endfunction

    function automatic kf_result_t kf_update(logic signed [31:0] meas_in,
                                             logic signed [31:0] gyro_in,
                                             logic [15:0] dt_in);
        longint meas, gyro, dt, p00, p01, p10, p11;
        longint rate, t, s, k0, k1, y, o00, o01;
        kf_result_t r;
        meas = longint'(meas_in);
        gyro = longint'(gyro_in);
        dt = longint'({48'd0, dt_in});
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        rate = sat(gyro - bias_est, 32);
        angle_est = sat(angle_est + fixmul(dt, rate, DT_FRAC, 32), 32);
        t = fixmul(dt, p11, DT_FRAC, 64);
        p00 = sat(p00 + fixmul(dt, t - p01 - p10 + longint'({40'd0, angle_noise}),
                               DT_FRAC, 64), COV_W);
        p01 = sat(p01 - t, COV_W);
        p10 = sat(p10 - t, COV_W);
        p11 = sat(p11 + fixmul(longint'({40'd0, bias_noise}), dt, DT_FRAC, 64), COV_W);
        s = p00 + longint'({40'd0, meas_noise});
        if (s > 0) begin
            k0 = gain(p00, s);
            k1 = gain(p10, s);
            y = sat(meas - angle_est, 32);
            angle_est = sat(angle_est + fixmul(k0, y, COV_FRAC, 32), 32);
            bias_est = sat(bias_est + fixmul(k1, y, COV_FRAC, 32), 32);
            o00 = p00;
            o01 = p01;
            p00 = sat(p00 - fixmul(k0, o00, COV_FRAC, 64), COV_W);
            p01 = sat(p01 - fixmul(k0, o01, COV_FRAC, 64), COV_W);
            p10 = sat(p10 - fixmul(k1, o00, COV_FRAC, 64), COV_W);
            p11 = sat(p11 - fixmul(k1, o01, COV_FRAC, 64), COV_W);
        end
        cov[0] = p00;
        cov[1] = p01;
        cov[2] = p10;
        cov[3] = p11;
        r.angle = angle_est[31:0];
        r.rate = rate[31:0];
        r.bias = bias_est[31:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        kf_result_t e;
        if (!i_rst_n) begin
            angle_noise = QA_RST;
            bias_noise = QB_RST;
            meas_noise = R_RST;
            angle_est = 0;
            bias_est = 0;
            cov = '{0, 0, 0, 0};
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_QA: angle_noise = i_cfg_data[REG_W-1:0];
                    REG_QB: bias_noise = i_cfg_data[REG_W-1:0];
                    REG_R: meas_noise = i_cfg_data[REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_estimates.push_back(kf_update(i_measured_angle, i_gyro_rate,
                                                       i_time_step));
            if (i_out_valid && i_out_ready) begin
                if (expected_estimates.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    o_fail_count++;
                end else begin
                    e = expected_estimates.pop_front();
                    if (i_filtered_angle !== e.angle) begin
                        $error("filtered_angle: expected %0d, got %0d",
                               $signed(e.angle), i_filtered_angle);
                        o_fail_count++;
                    end
                    if (i_unbiased_rate !== e.rate) begin
                        $error("unbiased_rate: expected %0d, got %0d",
                               $signed(e.rate), i_unbiased_rate);
                        o_fail_count++;
                    end
                    if (i_bias_estimate !== e.bias) begin
                        $error("bias_estimate: expected %0d, got %0d",
                               $signed(e.bias), i_bias_estimate);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_estimates.size();
    end
endmodule

[test/tb_angle_bias_kalman_filter.sv]
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 100;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic signed [IO_W-1:0] i_measured_angle, i_gyro_rate;
    logic [DT_W-1:0] i_time_step;
    logic o_out_valid, i_out_ready;
    logic signed [IO_W-1:0] o_filtered_angle, o_unbiased_rate, o_bias_estimate;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int fail_count, pending;
    int results_seen;
    bit no_idle;

    angle_bias_kalman_filter dut (.*);

    kf_state_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready),
        .i_measured_angle, .i_gyro_rate, .i_time_step,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_filtered_angle(o_filtered_angle), .i_unbiased_rate(o_unbiased_rate),
        .i_bias_estimate(o_bias_estimate),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        bit held;
        held = 0;
        results_seen = 0;
        i_out_ready <= 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) results_seen++;
            if (!held && results_seen == 200) begin
                held = 1;
                i_out_ready <= 0;
                repeat (400) @(posedge i_clk);
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    task automatic send_reading(logic signed [31:0] m, logic signed [31:0] g,
                                logic [15:0] dt);
        if (!no_idle && $urandom_range(99) < 11) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_measured_angle <= m;
        i_gyro_rate <= g;
        i_time_step <= dt;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_random();
        logic signed [31:0] m, g;
        logic [15:0] dt;
        if ($urandom_range(99) < 80) begin
            m = $urandom_range(0, 6_000_000);
            g = $urandom_range(0, 20_000_000);
            if ($urandom_range(1)) m = -m;
            if ($urandom_range(1)) g = -g;
            dt = 16'($urandom_range(1, 1311));
        end else begin
            m = $urandom;
            g = $urandom;
            dt = 16'($urandom);
        end
        send_reading(m, g, dt);
    endtask

    initial begin
        i_rst_n <= 0;
        i_in_valid <= 0;
        i_measured_angle <= 0;
        i_gyro_rate <= 0;
        i_time_step <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= REG_QA;
        i_cfg_data <= 0;
        no_idle = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, zero and full time step
        send_reading(0, 0, 0);
        send_reading(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
        send_reading(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
        send_reading(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001);
        send_reading(32'sh8000_0000, 32'sh7FFF_FFFF, 16'h8000);
        send_reading(-1, 1, 16'hFFFF);
        send_reading(1 << 16, -(1 << 16), 655);
        send_reading(45 << 16, 10 << 16, 655);
        send_reading(-(45 << 16), -(10 << 16), 0);
        drain();
        // extreme noise settings, out of range index, upper data bits
        write_reg(REG_QA, 32'hFFFF_FFFF);
        write_reg(REG_QB, 32'hFFFF_FFFF);
        write_reg(REG_R, 32'hFF00_0001);
        write_reg(REG_UNUSED, 32'h0000_0000);
        send_reading(32'sh7FFF_FFFF, 0, 16'hFFFF);
        send_reading(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
        send_reading(12345, -54321, 16'hFFFF);
        drain();
        // zero measurement noise: innovation variance can be non-positive
        write_reg(REG_QA, 0);
        write_reg(REG_QB, 0);
        write_reg(REG_R, 0);
        send_reading(10 << 16, 1 << 16, 100);
        send_reading(-(10 << 16), 0, 0);
        send_reading(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_QA, CFG_DATA_W'(QA_RST));
                    write_reg(REG_QB, CFG_DATA_W'(QB_RST));
                    write_reg(REG_R, CFG_DATA_W'(R_RST));
                end
                1: begin
                    write_reg(REG_QA, 0);
                    write_reg(REG_QB, 0);
                    write_reg(REG_R, 1);
                end
                2: begin
                    write_reg(REG_QA, 32'h00FF_FFFF);
                    write_reg(REG_QB, 32'h00FF_FFFF);
                    write_reg(REG_R, 32'h00FF_FFFF);
                end
                3: begin
                    write_reg(REG_QA, $urandom);
                    write_reg(REG_QB, $urandom);
                    write_reg(REG_R, $urandom);
                    write_reg(REG_UNUSED, $urandom);
                end
                4: write_reg(REG_R, 0);
                default: begin
                    write_reg(REG_QA, $urandom_range(0, 100_000));
                    write_reg(REG_QB, $urandom_range(0, 100_000));
                    write_reg(REG_R, $urandom_range(1, 1_000_000));
                end
            endcase
            for (int n = 0; n < 315; n++) begin
                no_idle = (phase == 2 && n >= 50 && n < 200);
                if (phase == 3 && n == 150) begin
                    i_in_valid <= 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_random();
            end
            no_idle = 0;
            drain();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
